// ===== rtl/core/zwht_pkg.sv =====
package zwht_pkg;

  localparam int unsigned COORD_FIELD_W = 12;
  localparam int unsigned NUM_IN_COORDS = 6;
  localparam int unsigned IN_TDATA_W    = 72;
  localparam int unsigned WIN_ID_W      = 5;
  localparam int unsigned OUT_TDATA_W   = 8;

  localparam int unsigned IDX_WIN_LEFT   = 0;
  localparam int unsigned IDX_WIN_BOTTOM = 1;
  localparam int unsigned IDX_WIN_RIGHT  = 2;
  localparam int unsigned IDX_WIN_TOP    = 3;
  localparam int unsigned IDX_POINT_X    = 4;
  localparam int unsigned IDX_POINT_Y    = 5;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CLICK = 1'b1;

  typedef struct packed {
    logic shift;
    logic capture;
  } cell_ctl_t;

endpackage

// ===== rtl/core/zorder_window_hit_test_unit.sv =====
// Z-ordered window hit tester. A load request (tuser = 0) pushes a rectangle on top of the
// stack and gives no response; a load into a full stack is dropped. A click request
// (tuser = 1) is done in steps: first every cell of the stack compares the point against its
// own rectangle, then the topmost hit is found, its id is sent out and the stack shifts
// down by one cell above the hit so that the window lands on top. The input stalls only
// while a click waits between those steps, also while its response waits for a free output
// register. Ids count from 1 in load order.
module zorder_window_hit_test_unit #(
  parameter int unsigned MAX_WINDOWS = 16,
  parameter int unsigned COORD_BITS  = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // win_left, win_bottom, win_right, win_top, point_x, point_y (12 bits each)
  input  logic [zwht_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // op
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // window_id (5 bits), then zero padding
  output logic [zwht_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // hit
  output logic                           m_axis_tuser
);

  localparam int unsigned ID_W   = $clog2(MAX_WINDOWS + 1);
  localparam int unsigned EntryW = 4 * COORD_BITS + ID_W;
  localparam int unsigned FieldW = zwht_pkg::COORD_FIELD_W;
  localparam int unsigned IdOutW = zwht_pkg::WIN_ID_W;
  localparam logic [ID_W-1:0] MaxCnt = ID_W'(MAX_WINDOWS);
  localparam logic [MAX_WINDOWS-1:0] AllOnes = {MAX_WINDOWS{1'b1}};

  logic [ID_W-1:0]        count_q, count_d;
  logic                   busy_q, busy_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_hit_q, out_hit_d;
  logic [IdOutW-1:0]      out_id_q, out_id_d;

  logic [COORD_BITS-1:0]  coord [zwht_pkg::NUM_IN_COORDS];
  logic                   s_fire, load_ok, click, resolve;
  logic [EntryW-1:0]      new_entry, head_entry, sel_entry;
  logic [EntryW-1:0]      entry [MAX_WINDOWS];
  logic [MAX_WINDOWS-1:0] match, upto, first, move;
  logic                   hit_any;
  logic [ID_W+IdOutW-1:0] id_ext;
  zwht_pkg::cell_ctl_t    ctl [MAX_WINDOWS];

  for (genvar k = 0; k < zwht_pkg::NUM_IN_COORDS; k++) begin : g_coord
    logic [FieldW+COORD_BITS-1:0] ext;
    assign ext      = {{COORD_BITS{1'b0}}, s_axis_tdata[k*FieldW +: FieldW]};
    assign coord[k] = ext[COORD_BITS-1:0];
  end

  assign s_axis_tready = !busy_q;
  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign load_ok = s_fire && (s_axis_tuser == zwht_pkg::OP_LOAD) && (count_q < MaxCnt);
  assign click   = s_fire && (s_axis_tuser == zwht_pkg::OP_CLICK);
  assign resolve = busy_q && (!out_valid_q || m_axis_tready);

  assign new_entry = {count_q + ID_W'(1),
                      coord[zwht_pkg::IDX_WIN_TOP],
                      coord[zwht_pkg::IDX_WIN_RIGHT],
                      coord[zwht_pkg::IDX_WIN_BOTTOM],
                      coord[zwht_pkg::IDX_WIN_LEFT]};

  always_comb begin
    sel_entry = '0;
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      upto[i] = |(match & (AllOnes >> (MAX_WINDOWS - 1 - i)));
    end
    first = match & ~(upto << 1);
    move  = ~(upto << 1) & {MAX_WINDOWS{|match}};
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      sel_entry = sel_entry | ({EntryW{first[i]}} & entry[i]);
    end
  end

  assign hit_any    = |match;
  assign head_entry = load_ok ? new_entry : sel_entry;

  for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
    logic [EntryW-1:0] shift_in;
    logic              valid;

    if (i == 0) begin : g_head
      assign shift_in = head_entry;
    end else begin : g_body
      assign shift_in = entry[i-1];
    end

    assign valid         = ID_W'(i) < count_q;
    assign ctl[i].shift   = load_ok || (resolve && move[i]);
    assign ctl[i].capture = click;

    zwht_cell #(
      .COORD_BITS (COORD_BITS),
      .ID_W       (ID_W)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl[i]),
      .valid_i    (valid),
      .shift_in_i (shift_in),
      .point_x_i  (coord[zwht_pkg::IDX_POINT_X]),
      .point_y_i  (coord[zwht_pkg::IDX_POINT_Y]),
      .entry_o    (entry[i]),
      .match_o    (match[i])
    );
  end

  assign id_ext = {{IdOutW{1'b0}}, sel_entry[4*COORD_BITS +: ID_W]};

  always_comb begin
    count_d     = count_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    out_id_d    = out_id_q;
    if (load_ok) begin
      count_d = count_q + ID_W'(1);
    end
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (resolve) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      out_hit_d   = hit_any;
      out_id_d    = id_ext[IdOutW-1:0];
    end
    if (click) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hit_q <= out_hit_d;
    out_id_q  <= out_id_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = {{(zwht_pkg::OUT_TDATA_W - IdOutW){1'b0}}, out_id_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("Window count exceeds the stack depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && hit_any |-> $onehot(first))
    else $error("Topmost hit selection is not one-hot.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_ok |=> count_q == $past(count_q) + ID_W'(1))
    else $error("Accepted load did not advance the window count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    resolve |=> out_valid_q && !busy_q)
    else $error("Resolved click did not produce a response.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !resolve |=> busy_q && $stable(match))
    else $error("Pending click lost its match vector.");

endmodule

// ===== rtl/core/zwht_cell.sv =====
module zwht_cell #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned ID_W       = 5
) (
  input  logic                           clk_i,
  input  zwht_pkg::cell_ctl_t            ctl_i,
  input  logic                           valid_i,
  input  logic [4*COORD_BITS+ID_W-1:0]   shift_in_i,
  input  logic [COORD_BITS-1:0]          point_x_i,
  input  logic [COORD_BITS-1:0]          point_y_i,
  output logic [4*COORD_BITS+ID_W-1:0]   entry_o,
  output logic                           match_o
);

  localparam int unsigned EntryW = 4 * COORD_BITS + ID_W;

  logic [EntryW-1:0]     entry_q;
  logic                  match_q;
  logic [COORD_BITS-1:0] left, bottom, right, top;
  logic                  contains;

  assign left   = entry_q[0*COORD_BITS +: COORD_BITS];
  assign bottom = entry_q[1*COORD_BITS +: COORD_BITS];
  assign right  = entry_q[2*COORD_BITS +: COORD_BITS];
  assign top    = entry_q[3*COORD_BITS +: COORD_BITS];

  assign contains = valid_i && (point_x_i >= left) && (point_x_i <= right) &&
                    (point_y_i >= bottom) && (point_y_i <= top);

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      entry_q <= shift_in_i;
    end
    if (ctl_i.capture) begin
      match_q <= contains;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ===== verif/zorder_window_hit_test_unit_test.sv =====
`timescale 1ns / 1ps

module zorder_window_hit_test_unit_test;

  localparam int unsigned WINDOW_SLOTS = 16;
  localparam int unsigned CW           = zwht_pkg::COORD_FIELD_W;
  localparam int unsigned IDW          = zwht_pkg::WIN_ID_W;
  localparam int unsigned INW          = zwht_pkg::IN_TDATA_W;
  localparam int unsigned OUTW         = zwht_pkg::OUT_TDATA_W;
  localparam int unsigned REQUEST_GOAL = 400;
  localparam int unsigned CALM_TAIL    = 60;
  localparam int unsigned DRAIN_LIMIT  = 2000;

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    coord_t         left;
    coord_t         bottom;
    coord_t         right;
    coord_t         top;
    logic [IDW-1:0] id;
  } window_rect_t;

  typedef struct packed {
    logic           hit;
    logic [IDW-1:0] id;
  } click_outcome_t;

  class window_stack_scoreboard;
    window_rect_t   stack_q[$];
    click_outcome_t outcome_q[$];
    int unsigned    loaded;
    int unsigned    failures;
    int unsigned    clicks;
    int unsigned    hits;
    int unsigned    dropped_loads;

    function new();
      loaded        = 0;
      failures      = 0;
      clicks        = 0;
      hits          = 0;
      dropped_loads = 0;
    endfunction

    function bit covers_point(window_rect_t w, coord_t px, coord_t py);
      return px >= w.left && px <= w.right && py >= w.bottom && py <= w.top;
    endfunction

    function void note_request(logic op, logic [INW-1:0] data);
      window_rect_t   w;
      click_outcome_t res;
      coord_t         px;
      coord_t         py;
      int             found;
      if (op == zwht_pkg::OP_LOAD) begin
        if (loaded >= WINDOW_SLOTS) begin
          dropped_loads++;
        end else begin
          w.left   = data[zwht_pkg::IDX_WIN_LEFT*CW +: CW];
          w.bottom = data[zwht_pkg::IDX_WIN_BOTTOM*CW +: CW];
          w.right  = data[zwht_pkg::IDX_WIN_RIGHT*CW +: CW];
          w.top    = data[zwht_pkg::IDX_WIN_TOP*CW +: CW];
          w.id     = IDW'(loaded + 1);
          stack_q.push_front(w);
          loaded++;
        end
      end else begin
        px    = data[zwht_pkg::IDX_POINT_X*CW +: CW];
        py    = data[zwht_pkg::IDX_POINT_Y*CW +: CW];
        found = -1;
        for (int i = 0; i < stack_q.size(); i++) begin
          if (found < 0 && covers_point(stack_q[i], px, py)) begin
            found = i;
          end
        end
        res = '0;
        if (found >= 0) begin
          w = stack_q[found];
          stack_q.delete(found);
          stack_q.push_front(w);
          res.hit = 1'b1;
          res.id  = w.id;
          hits++;
        end
        clicks++;
        outcome_q.push_back(res);
      end
    endfunction

    function void check_response(logic hit, logic [OUTW-1:0] data);
      click_outcome_t  exp_res;
      logic [OUTW-1:0] exp_data;
      if (outcome_q.size() == 0) begin
        failures++;
        $display("%0t: unexpected response hit=%0b tdata=0x%0h", $time, hit, data);
      end else begin
        exp_res  = outcome_q.pop_front();
        exp_data = OUTW'(exp_res.id);
        if (hit !== exp_res.hit || data !== exp_data) begin
          failures++;
          $display("%0t: mismatch: expected hit=%0b tdata=0x%0h, actual hit=%0b tdata=0x%0h",
                   $time, exp_res.hit, exp_data, hit, data);
        end
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [INW-1:0]  s_axis_tdata;
  logic            s_axis_tuser;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [OUTW-1:0] m_axis_tdata;
  logic            m_axis_tuser;

  window_stack_scoreboard sb;
  bit                     calm_sink;
  bit                     sender_idles;
  int unsigned            sent_work;

  zorder_window_hit_test_unit #(
    .MAX_WINDOWS(WINDOW_SLOTS),
    .COORD_BITS (CW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic logic [INW-1:0] pack_request(coord_t left, coord_t bottom,
                                                   coord_t right, coord_t top,
                                                   coord_t px, coord_t py);
    logic [INW-1:0] data;
    data = '0;
    data[zwht_pkg::IDX_WIN_LEFT*CW +: CW]   = left;
    data[zwht_pkg::IDX_WIN_BOTTOM*CW +: CW] = bottom;
    data[zwht_pkg::IDX_WIN_RIGHT*CW +: CW]  = right;
    data[zwht_pkg::IDX_WIN_TOP*CW +: CW]    = top;
    data[zwht_pkg::IDX_POINT_X*CW +: CW]    = px;
    data[zwht_pkg::IDX_POINT_Y*CW +: CW]    = py;
    return data;
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom_range(0, (1 << CW) - 1));
  endfunction

  task automatic hold_sender(int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_request(logic op, logic [INW-1:0] data);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(op, data);
    if (sender_idles && !calm_sink && $urandom_range(0, 4) == 0) begin
      hold_sender($urandom_range(1, 7));
    end
  endtask

  task automatic send_load(coord_t left, coord_t bottom, coord_t right, coord_t top);
    send_request(zwht_pkg::OP_LOAD,
                 pack_request(left, bottom, right, top, any_coord(), any_coord()));
  endtask

  task automatic send_click(coord_t px, coord_t py);
    send_request(zwht_pkg::OP_CLICK,
                 pack_request(any_coord(), any_coord(), any_coord(), any_coord(), px, py));
  endtask

  task automatic send_random_load();
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
    int     span_x;
    int     span_y;
    left   = any_coord();
    bottom = any_coord();
    span_x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 1200);
    span_y = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 1200);
    right  = (left + span_x > 4095) ? coord_t'(4095) : coord_t'(left + span_x);
    top    = (bottom + span_y > 4095) ? coord_t'(4095) : coord_t'(bottom + span_y);
    // Some windows are inverted on one axis and cannot be hit unless that axis has zero span.
    case ($urandom_range(0, 9))
      0: send_load(right, bottom, left, top);
      1: send_load(left, top, right, bottom);
      default: send_load(left, bottom, right, top);
    endcase
  endtask

  task automatic send_random_click();
    window_rect_t w;
    coord_t       px;
    coord_t       py;
    px = any_coord();
    py = any_coord();
    if (sb.stack_q.size() != 0 && $urandom_range(0, 3) != 0) begin
      w = sb.stack_q[$urandom_range(0, sb.stack_q.size() - 1)];
      if (w.left <= w.right && w.bottom <= w.top) begin
        px = coord_t'($urandom_range(w.left, w.right));
        py = coord_t'($urandom_range(w.bottom, w.top));
      end
    end
    send_click(px, py);
  endtask

  task automatic wait_for_outcomes();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.outcome_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= zwht_pkg::OP_LOAD;
    m_axis_tready <= 1'b0;
    rst_ni        <= 1'b0;
    calm_sink     = 1'b0;
    sender_idles  = 1'b0;
    sent_work     = 0;
    sb            = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty stack, corners, inverted windows, inclusive edges and reordering.
    send_click(0, 0);
    send_click(4095, 4095);
    send_load(0, 0, 5, 5);
    send_load(4090, 4090, 4095, 4095);
    send_load(100, 100, 50, 50);
    send_load(200, 300, 400, 250);
    send_click(0, 0);
    send_click(4095, 4095);
    send_click(75, 75);
    send_click(300, 275);
    send_click(5, 5);
    send_click(6, 5);
    send_load(3, 3, 10, 10);
    send_click(4, 4);
    send_click(4, 4);
    send_click(1, 1);
    send_click(4, 4);
    send_click(10, 10);
    send_load(2048, 2048, 2048, 2048);
    send_click(2048, 2048);
    send_click(2049, 2048);
    send_click(4090, 4089);

    sender_idles = 1'b1;
    while (sent_work < REQUEST_GOAL) begin
      if (sent_work == REQUEST_GOAL / 2) begin
        wait_for_outcomes();
      end
      if (sent_work >= REQUEST_GOAL - CALM_TAIL) begin
        calm_sink = 1'b1;
      end
      if (sb.loaded < WINDOW_SLOTS && $urandom_range(0, 2) == 0) begin
        send_random_load();
        sent_work++;
      end else if (sb.loaded >= WINDOW_SLOTS && $urandom_range(0, 9) == 0) begin
        send_random_load();
        sent_work++;
      end else begin
        send_random_click();
        sent_work++;
      end
    end

    s_axis_tvalid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && sb.outcome_q.size() != 0; n++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.outcome_q.size() != 0) begin
      sb.failures++;
      $display("%0t: %0d click responses never arrived", $time, sb.outcome_q.size());
    end
    $display("Loaded %0d windows and dropped %0d loads into the full stack.",
             sb.loaded, sb.dropped_loads);
    $display("Sent %0d clicks, %0d of them hits and %0d misses.",
             sb.clicks, sb.hits, sb.clicks - sb.hits);
    if (sb.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      if (calm_sink) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        if (!calm_sink) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_response(m_axis_tuser, m_axis_tdata);
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/zwht_pkg.sv
rtl/core/zwht_cell.sv
rtl/core/zorder_window_hit_test_unit.sv
verif/zorder_window_hit_test_unit_test.sv
